// ===== hdl/rnid_pkg.sv =====
package rnid_pkg;

  // field widths of the channels and the configuration port
  localparam int CODE_W      = 8;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int GROUP_W     = 64;
  localparam int PCOUNT_W    = 5;
  localparam int GROUP_BYTES = GROUP_W / 8;

  // decoded byte counter and limit
  localparam int BCNT_W = 21;
  localparam int PROD_W = 2 * CFG_W;
  // longest run of one token in bytes (pair run of 255 pairs)
  localparam int RUN_W  = 9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_PAIRS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'd1;

  // configuration reset values
  localparam logic [CFG_W-1:0] COLUMN_PAIRS_RST = 11'd320;
  localparam logic [CFG_W-1:0] ROW_COUNT_RST    = 11'd400;

  // escape tokens of the compressed stream
  localparam logic [CODE_W-1:0] TOK_PAIR = 8'hFE;
  localparam logic [CODE_W-1:0] TOK_FILL = 8'hFF;

  // kind of run started in the datapath
  localparam logic [1:0] RUN_LIT  = 2'd0;
  localparam logic [1:0] RUN_FILL = 2'd1;
  localparam logic [1:0] RUN_PAIR = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic       ld_count;
    logic       ld_first;
    logic       start;
    logic [1:0] run_sel;
    logic       emit;
    logic       clr_bw;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tok_pair;
    logic tok_fill;
    logic lim_full;
    logic run_empty;
    logic last_group;
  } dp_sts_t;

endpackage

// ===== hdl/rnid_chan_if.sv =====
// compressed byte channel
interface rnid_in_if;
  logic                         valid;
  logic                         ready;
  logic [rnid_pkg::CODE_W-1:0]  code_byte;
  logic                         stream_end;

  modport source (output valid, code_byte, stream_end, input ready);
  modport sink   (input valid, code_byte, stream_end, output ready);
endinterface

// pixel group channel
interface rnid_out_if;
  logic                          valid;
  logic                          ready;
  logic [rnid_pkg::GROUP_W-1:0]  pixel_group;
  logic [rnid_pkg::PCOUNT_W-1:0] pixel_count;
  logic                          run_last;
  logic                          image_done;

  modport source (output valid, pixel_group, pixel_count, run_last, image_done, input ready);
  modport sink   (input valid, pixel_group, pixel_count, run_last, image_done, output ready);
endinterface

// ===== hdl/rnid_dp.sv =====
module rnid_dp #(
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rnid_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rnid_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [rnid_pkg::CODE_W-1:0]       in_code_byte,
  input  rnid_pkg::dp_cmd_t                 cmd,
  output rnid_pkg::dp_sts_t                 sts,
  output logic [rnid_pkg::GROUP_W-1:0]      out_pixel_group,
  output logic [rnid_pkg::PCOUNT_W-1:0]     out_pixel_count,
  output logic                              out_run_last,
  output logic                              out_image_done
);

  localparam int KW = $clog2(BYTES_PER_RESULT + 1);

  logic [rnid_pkg::CFG_W-1:0]   col_r, row_r;
  logic [rnid_pkg::PROD_W-1:0]  prod;
  logic [rnid_pkg::BCNT_W-1:0]  lim_r;
  logic [rnid_pkg::CODE_W-1:0]  run_len_r, first_r, pat_a_r, pat_b_r;
  logic [rnid_pkg::BCNT_W-1:0]  bw_r, bw_add, room;
  logic [rnid_pkg::RUN_W-1:0]   rem_r, total, n_bytes;
  logic                         par_r;
  logic [KW-1:0]                k;
  logic [rnid_pkg::GROUP_W-1:0] group;
  logic [rnid_pkg::GROUP_W-1:0] group_r;
  logic [rnid_pkg::PCOUNT_W-1:0] count_r;
  logic                         last_r, done_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= rnid_pkg::COLUMN_PAIRS_RST;
      row_r <= rnid_pkg::ROW_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rnid_pkg::CFG_COLUMN_PAIRS: col_r <= cfg_wdata;
        rnid_pkg::CFG_ROW_COUNT:    row_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // byte limit, saturated to the counter range
  assign prod = col_r * row_r;

  always_ff @(posedge clk) begin
    lim_r <= prod[rnid_pkg::PROD_W-1] ? '1 : prod[rnid_pkg::BCNT_W-1:0];
  end

  // run length in bytes of the token being completed, cut at the limit
  always_comb begin
    case (cmd.run_sel)
      rnid_pkg::RUN_LIT:  total = rnid_pkg::RUN_W'(1);
      rnid_pkg::RUN_FILL: total = {1'b0, run_len_r};
      rnid_pkg::RUN_PAIR: total = {run_len_r, 1'b0};
      default:            total = '0;
    endcase
  end

  assign room    = lim_r - bw_r;
  assign n_bytes = (rnid_pkg::BCNT_W'(total) < room) ? total : room[rnid_pkg::RUN_W-1:0];

  // bytes in the group being built
  assign k = (rem_r < rnid_pkg::RUN_W'(BYTES_PER_RESULT)) ?
             rem_r[KW-1:0] : KW'(BYTES_PER_RESULT);
  assign bw_add = bw_r + rnid_pkg::BCNT_W'(k);

  // alternate the two pattern bytes, first byte in the low lane
  always_comb begin
    group = '0;
    for (int j = 0; j < rnid_pkg::GROUP_BYTES; j++) begin
      if (j < int'(k)) begin
        group[8*j +: 8] = (par_r ^ j[0]) ? pat_b_r : pat_a_r;
      end
    end
  end

  // header bytes
  always_ff @(posedge clk) begin
    if (cmd.ld_count) begin
      run_len_r <= in_code_byte;
    end
    if (cmd.ld_first) begin
      first_r <= in_code_byte;
    end
  end

  // run in progress
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pat_a_r <= (cmd.run_sel == rnid_pkg::RUN_PAIR) ? first_r : in_code_byte;
      pat_b_r <= in_code_byte;
      rem_r   <= n_bytes;
      par_r   <= 1'b0;
    end else if (cmd.emit) begin
      rem_r <= rem_r - rnid_pkg::RUN_W'(k);
      par_r <= par_r ^ k[0];
    end
  end

  // decoded byte counter
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_bw) begin
      bw_r <= '0;
    end else if (cmd.emit) begin
      bw_r <= bw_add;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      group_r <= group;
      count_r <= rnid_pkg::PCOUNT_W'({k, 1'b0});
      last_r  <= sts.last_group;
      done_r  <= (bw_add >= lim_r);
    end
  end

  assign out_pixel_group = group_r;
  assign out_pixel_count = count_r;
  assign out_run_last    = last_r;
  assign out_image_done  = done_r;

  // status
  assign sts.tok_pair   = (in_code_byte == rnid_pkg::TOK_PAIR);
  assign sts.tok_fill   = (in_code_byte == rnid_pkg::TOK_FILL);
  assign sts.lim_full   = (bw_r >= lim_r);
  assign sts.run_empty  = (n_bytes == '0);
  assign sts.last_group = (rem_r <= rnid_pkg::RUN_W'(BYTES_PER_RESULT));

endmodule

// ===== hdl/rnid_ctrl.sv =====
module rnid_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              in_valid,
  input  logic              in_stream_end,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rnid_pkg::dp_sts_t sts,
  output rnid_pkg::dp_cmd_t cmd
);

  // parser phases
  localparam logic [1:0] PH_TOKEN  = 2'd0;
  localparam logic [1:0] PH_COUNT  = 2'd1;
  localparam logic [1:0] PH_VALUE  = 2'd2;
  localparam logic [1:0] PH_SECOND = 2'd3;

  // emission states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic [1:0] phase_r, phase_nxt;
  logic       kind_r, kind_nxt;
  logic       state_r, state_nxt;
  logic       end_pend_r, end_pend_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       lim_ok_r;
  logic       in_fire;
  logic       go_emit;

  assign in_ready  = (state_r == ST_IDLE) && lim_ok_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // parser and emission sequencing
  always_comb begin
    phase_nxt     = phase_r;
    kind_nxt      = kind_r;
    state_nxt     = state_r;
    end_pend_nxt  = end_pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    go_emit       = 1'b0;
    cmd           = '0;
    cmd.run_sel   = rnid_pkg::RUN_LIT;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!sts.lim_full) begin
            case (phase_r)
              PH_TOKEN: begin
                if (sts.tok_pair) begin
                  kind_nxt  = 1'b1;
                  phase_nxt = PH_COUNT;
                end else if (sts.tok_fill) begin
                  kind_nxt  = 1'b0;
                  phase_nxt = PH_COUNT;
                end else begin
                  cmd.start   = 1'b1;
                  cmd.run_sel = rnid_pkg::RUN_LIT;
                  go_emit     = !sts.run_empty;
                end
              end
              PH_COUNT: begin
                cmd.ld_count = 1'b1;
                phase_nxt    = PH_VALUE;
              end
              PH_VALUE: begin
                if (kind_r) begin
                  cmd.ld_first = 1'b1;
                  phase_nxt    = PH_SECOND;
                end else begin
                  cmd.start   = 1'b1;
                  cmd.run_sel = rnid_pkg::RUN_FILL;
                  go_emit     = !sts.run_empty;
                  phase_nxt   = PH_TOKEN;
                end
              end
              default: begin
                cmd.start   = 1'b1;
                cmd.run_sel = rnid_pkg::RUN_PAIR;
                go_emit     = !sts.run_empty;
                phase_nxt   = PH_TOKEN;
              end
            endcase
          end
          if (go_emit) begin
            state_nxt = ST_EMIT;
          end
          // end of stream: parser restarts, counter clears once the run is out
          if (in_stream_end) begin
            phase_nxt = PH_TOKEN;
            kind_nxt  = 1'b0;
            if (go_emit) begin
              end_pend_nxt = 1'b1;
            end else begin
              cmd.clr_bw = 1'b1;
            end
          end
        end
      end
      default: begin
        cmd.emit = !out_valid_r || out_ready;
        if (cmd.emit) begin
          out_valid_nxt = 1'b1;
          if (sts.last_group) begin
            state_nxt    = ST_IDLE;
            cmd.clr_bw   = end_pend_r;
            end_pend_nxt = 1'b0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TOKEN;
      kind_r      <= 1'b0;
      state_r     <= ST_IDLE;
      end_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      kind_r      <= kind_nxt;
      state_r     <= state_nxt;
      end_pend_r  <= end_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input held until the limit register settles after a configuration write
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      lim_ok_r <= 1'b0;
    end else begin
      lim_ok_r <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_start_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && !sts.run_empty) |=> (state_r == ST_EMIT))
    else $error("run with bytes did not enter emission");

  a_last_group_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && cmd.emit && sts.last_group) |=>
      (state_r == ST_IDLE && out_valid_r))
    else $error("final group did not end emission");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input taken while limit is stale");

  a_end_pend_emit: assert property (@(posedge clk) disable iff (!rst_n)
    end_pend_r |-> (state_r == ST_EMIT))
    else $error("pending stream end outside emission");
`endif

endmodule

// ===== hdl/rle_nibble_image_decoder_unit.sv =====
// run-length image decoder, 4-bit pixels
//
// in_chan carries one compressed byte per beat with stream_end on the last
// byte of a stream. out_chan carries groups of up to BYTES_PER_RESULT decoded
// bytes (two pixels each, first pixel in the lowest nibble) with run_last on
// the final group of a token and image_done once the byte limit is reached.
// cfg_we/cfg_index/cfg_wdata write image width in bytes and height in rows.
//
// header and escape bytes are accepted and emit no group. a literal is
// accepted, then its group is loaded into the output register. a run of n
// bytes holds in_chan.ready low while its groups of up to BYTES_PER_RESULT
// bytes go out, one group per cycle unless out_chan stalls. the first group
// is loaded in the emission state entered after the completing byte is taken.
//
// after reset the width and height are 320 and 400 and the input is held
// while the limit product settles into its register; each configuration
// write adds the same pause. when out_chan stalls, the output register holds
// its group and emission waits; input stays blocked until the run's final
// group is loaded, then the next byte is taken while that group still waits.
module rle_nibble_image_decoder_unit #(
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rnid_in_if.sink                        in_chan,
  rnid_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [rnid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rnid_pkg::CFG_W-1:0]     cfg_wdata
);

  rnid_pkg::dp_cmd_t cmd;
  rnid_pkg::dp_sts_t sts;

  // sequencing of parser and emission
  rnid_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .in_valid      (in_chan.valid),
    .in_stream_end (in_chan.stream_end),
    .in_ready      (in_chan.ready),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  // counters, limit and group building
  rnid_dp #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_code_byte    (in_chan.code_byte),
    .cmd             (cmd),
    .sts             (sts),
    .out_pixel_group (out_chan.pixel_group),
    .out_pixel_count (out_chan.pixel_count),
    .out_run_last    (out_chan.run_last),
    .out_image_done  (out_chan.image_done)
  );

endmodule
